[rtl/core/pgtb_pkg.sv]
// ----------------------------------------------------------------------------
// pgtb_pkg: shared types and constants of the proportional glyph tile blitter
// Holds the glyph width table, the nibble opacity function and the types
// passed between the row lanes, the output stage and the top level.
// ----------------------------------------------------------------------------
package pgtb_pkg;

    localparam int unsigned ROWS       = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NIBBLES    = 8;
    localparam int unsigned OUT_DEPTH  = 2 * ROWS;
    localparam int unsigned TILE_IDX_W = 5;

    localparam logic [WORD_W-1:0] FILL_RESET = 32'h2222_2222;
    localparam logic [6:0]        FIRST_CODE = 7'd32;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_tile_rows [ROWS];

    // Bookkeeping that travels with one glyph's words into the output stage.
    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile0;
        logic                  split;
        logic                  overflow;
    } t_blit_info;

    // Pixel widths of the printable codes, starting at the space character.
    localparam logic [3:0] GLYPH_WIDTH [96] = '{
        4'd3, 4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3,
        4'd3, 4'd3, 4'd6, 4'd6, 4'd3, 4'd5, 4'd3, 4'd5,
        4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd5, 4'd5, 4'd6,
        4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd7,
        4'd6, 4'd7, 4'd6, 4'd3, 4'd5, 4'd3, 4'd6, 4'd5,
        4'd3, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd3, 4'd6, 4'd6, 4'd3, 4'd7, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7,
        4'd7, 4'd6, 4'd6, 4'd4, 4'd2, 4'd4, 4'd7, 4'd1
    };

    // Control codes below the space character have no width.
    function automatic logic [3:0] glyph_width(input logic [6:0] code);
        logic [6:0] idx;
        idx = code - FIRST_CODE;
        if (code < FIRST_CODE) begin
            return 4'd0;
        end
        return GLYPH_WIDTH[idx];
    endfunction

    // All ones in every nibble whose pixel is opaque (not zero).
    function automatic t_word opaque_mask(input t_word pix);
        t_word m;
        m = '0;
        for (int k = 0; k < NIBBLES; k++) begin
            if (pix[4*k +: 4] != 4'h0) begin
                m[4*k +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

[rtl/core/pgtb_lane.sv]
// ----------------------------------------------------------------------------
// pgtb_lane: one glyph row lane
// Shifts one glyph row into place for the current and the next tile and
// merges it into both tile rows with zero pixels transparent.
// ----------------------------------------------------------------------------
module pgtb_lane
    import pgtb_pkg::*;
(
    input  t_word      i_glyph,
    input  logic [2:0] i_offset,
    input  t_word      i_cur,
    input  t_word      i_nxt,
    input  logic       i_keep0,
    input  logic       i_keep1,
    output t_word      o_word0,
    output t_word      o_word1
);

    t_word      pix0;
    t_word      pix1;
    t_word      mask0;
    t_word      mask1;
    logic [5:0] rshift;

    assign rshift = 6'd32 - {1'b0, i_offset, 2'b00};

    always_comb begin
        pix0 = i_glyph << {i_offset, 2'b00};
        if (i_offset == 3'd0) begin
            pix1 = '0;
        end else begin
            pix1 = i_glyph >> rshift;
        end
        mask0 = opaque_mask(pix0);
        mask1 = opaque_mask(pix1);
    end

    // A row that falls past the last tile is dropped and reads as zero.
    assign o_word0 = i_keep0 ? ((i_cur & ~mask0) | (pix0 & mask0)) : '0;
    assign o_word1 = i_keep1 ? ((i_nxt & ~mask1) | (pix1 & mask1)) : '0;

endmodule

[rtl/core/pgtb_merge.sv]
// ----------------------------------------------------------------------------
// pgtb_merge: result merge and output stage
// Collects the words of all lanes for one glyph and hands them out one transfer
// per cycle unless stalled, current tile first, then the next tile on a split.
// ----------------------------------------------------------------------------
module pgtb_merge
    import pgtb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_tile_rows            i_part0,
    input  t_tile_rows            i_part1,
    input  t_blit_info            i_info,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TILE_IDX_W-1:0] o_tile_index,
    output logic [2:0]            o_row,
    output t_word                 o_word,
    output logic                  o_last,
    output logic                  o_overflow
);

    logic       r_busy;
    logic [3:0] r_pos;
    t_blit_info r_info;
    t_word      r_words [OUT_DEPTH];

    logic xfer;
    logic at_end;
    logic done;

    assign xfer   = r_busy & ~i_stall;
    assign at_end = (r_pos[2:0] == 3'd7) && (r_pos[3] == r_info.split);
    assign done   = xfer & at_end;
    assign o_free = ~r_busy | done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (xfer) begin
            r_pos <= r_pos + 4'd1;
        end
    end

    // The word on the port always sits in entry zero; each transfer shifts.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= i_info;
            for (int k = 0; k < ROWS; k++) begin
                r_words[k]        <= i_part0[k];
                r_words[k + ROWS] <= i_part1[k];
            end
        end else if (xfer) begin
            for (int k = 0; k < OUT_DEPTH - 1; k++) begin
                r_words[k] <= r_words[k + 1];
            end
        end
    end

    assign o_valid      = r_busy;
    assign o_word       = r_words[0];
    assign o_row        = r_pos[2:0];
    assign o_tile_index = r_info.tile0 + {{(TILE_IDX_W-1){1'b0}}, r_pos[3]};
    assign o_last       = at_end;
    assign o_overflow   = r_info.overflow;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("glyph loaded while the output stage still holds words");

    a_load_starts_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (o_valid && o_row == 3'd0 && o_last == 1'b0))
        else $error("loaded glyph does not start at row zero");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_load) |=> !o_valid)
        else $error("output stays valid after the final word");

    a_no_split_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_info.split) |-> !r_pos[3])
        else $error("second tile sent for a glyph without a split");

endmodule

[rtl/core/proportional_glyph_tile_blitter.sv]
// The first word of a glyph is on the output in the cycle after its transfer.
// A glyph yields 8 words (16 when it reaches or crosses a tile edge), one per
// cycle from the output stage unless it stalls; the next item is taken in the
// cycle of the final word. Reset clears the cursor, the pixel offset and the
// output stage, and loads the fill word register with 0x22222222. Tile contents
// are undefined until a start.
// ----------------------------------------------------------------------------
// proportional_glyph_tile_blitter: proportional text into 4bpp tiles
// Eight row lanes shift and transparently merge one glyph into the current
// and the next tile; the merge stage sends the updated tile rows out.
// ----------------------------------------------------------------------------
module proportional_glyph_tile_blitter
    import pgtb_pkg::*;
#(
    parameter int unsigned MAX_TILES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: fill word used by a start item.
    input  logic                  i_cfg_we,
    input  logic [WORD_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [6:0]            i_char_code,
    input  logic [WORD_W-1:0]     i_glyph_row_0,
    input  logic [WORD_W-1:0]     i_glyph_row_1,
    input  logic [WORD_W-1:0]     i_glyph_row_2,
    input  logic [WORD_W-1:0]     i_glyph_row_3,
    input  logic [WORD_W-1:0]     i_glyph_row_4,
    input  logic [WORD_W-1:0]     i_glyph_row_5,
    input  logic [WORD_W-1:0]     i_glyph_row_6,
    input  logic [WORD_W-1:0]     i_glyph_row_7,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TILE_IDX_W-1:0] o_tile_index,
    output logic [2:0]            o_row,
    output logic [WORD_W-1:0]     o_word,
    output logic                  o_last,
    output logic                  o_overflow
);

    // The cursor must be able to hold MAX_TILES itself, where it saturates.
    localparam int unsigned CW = $clog2(MAX_TILES + 1);
    localparam logic [CW-1:0] LAST_TILE = CW'(MAX_TILES - 1);
    localparam logic [CW-1:0] END_TILE  = CW'(MAX_TILES);

    // Text only ever moves right, so once a tile is left behind it is never
    // read again. The line is therefore kept as a two-tile window: the tile
    // under the cursor and the one after it. Tiles further right still hold
    // the fill word latched by the last start item.
    logic [WORD_W-1:0] r_fill_word;
    logic [WORD_W-1:0] r_line_fill;
    logic [CW-1:0]     r_cursor;
    logic [2:0]        r_offset;
    t_tile_rows        r_cur;
    t_tile_rows        r_nxt;

    t_tile_rows glyph;
    t_tile_rows word0;
    t_tile_rows word1;
    t_blit_info info;
    logic       free;
    logic       accept;
    logic       glyph_go;
    logic       start_go;
    logic [3:0] width;
    logic [3:0] reach;
    logic       split;
    logic       keep0;
    logic       keep1;

    assign glyph[0] = i_glyph_row_0;
    assign glyph[1] = i_glyph_row_1;
    assign glyph[2] = i_glyph_row_2;
    assign glyph[3] = i_glyph_row_3;
    assign glyph[4] = i_glyph_row_4;
    assign glyph[5] = i_glyph_row_5;
    assign glyph[6] = i_glyph_row_6;
    assign glyph[7] = i_glyph_row_7;

    // An item is taken whenever the output stage is empty or is sending its
    // final word in this cycle.
    assign o_stall  = ~free;
    assign accept   = i_valid & ~o_stall;
    assign glyph_go = accept & i_kind;
    assign start_go = accept & ~i_kind;

    // A glyph spills into the next tile when it reaches the tile's right edge.
    assign width = glyph_width(i_char_code);
    assign reach = {1'b0, r_offset} + width;
    assign split = reach[3];

    // Rows beyond the last tile are dropped; the whole glyph is then flagged.
    assign keep0 = r_cursor < END_TILE;
    assign keep1 = r_cursor < LAST_TILE;

    assign info.tile0    = TILE_IDX_W'(r_cursor);
    assign info.split    = split;
    assign info.overflow = split ? ~keep1 : ~keep0;

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        pgtb_lane u_lane (
            .i_glyph  (glyph[r]),
            .i_offset (r_offset),
            .i_cur    (r_cur[r]),
            .i_nxt    (r_nxt[r]),
            .i_keep0  (keep0),
            .i_keep1  (keep1),
            .o_word0  (word0[r]),
            .o_word1  (word1[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_word <= FILL_RESET;
        end else if (i_cfg_we) begin
            r_fill_word <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_offset <= '0;
        end else if (start_go) begin
            r_cursor <= '0;
            r_offset <= '0;
        end else if (glyph_go) begin
            // The new offset is the low bits of the reach in both cases.
            r_offset <= reach[2:0];
            if (split && keep0) begin
                r_cursor <= r_cursor + CW'(1);
            end
        end
    end

    // Window contents. On a split the window slides one tile to the right and
    // a fresh tile, still holding the line's fill word, enters from the right.
    always_ff @(posedge i_clk) begin
        if (start_go) begin
            r_line_fill <= r_fill_word;
            for (int r = 0; r < ROWS; r++) begin
                r_cur[r] <= r_fill_word;
                r_nxt[r] <= r_fill_word;
            end
        end else if (glyph_go) begin
            for (int r = 0; r < ROWS; r++) begin
                if (split) begin
                    r_cur[r] <= word1[r];
                    r_nxt[r] <= r_line_fill;
                end else begin
                    r_cur[r] <= word0[r];
                end
            end
        end
    end

    pgtb_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (glyph_go),
        .i_part0      (word0),
        .i_part1      (word1),
        .i_info       (info),
        .o_free       (free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_index (o_tile_index),
        .o_row        (o_row),
        .o_word       (o_word),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

endmodule

[verif/pgtb_tb_pkg.sv]
// ----------------------------------------------------------------------------
// pgtb_tb_pkg: verification types for the proportional glyph tile blitter
// Item kinds and the packed glyph row bundle, shared by the stimulus top and
// the checker.
// ----------------------------------------------------------------------------
package pgtb_tb_pkg;

    typedef enum logic {
        ITEM_START = 1'b0,
        ITEM_GLYPH = 1'b1
    } item_kind_e;

    // Row 0 of the glyph sits in element 0.
    typedef logic [7:0][31:0] glyph_rows_t;

endpackage

[verif/pgtb_checker.sv]
// ----------------------------------------------------------------------------
// pgtb_checker: result predictor and scoreboard for the glyph tile blitter
// Watches the configuration port and both channels, keeps its own copy of the
// tile line, pen offset and cursor, and compares every output word in order.
// ----------------------------------------------------------------------------
module pgtb_checker
    import pgtb_pkg::*;
    import pgtb_tb_pkg::*;
#(
    parameter int unsigned MAX_TILES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_kind,
    input  logic [6:0]            i_char_code,
    input  glyph_rows_t           i_glyph,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [TILE_IDX_W-1:0] i_tile_index,
    input  logic [2:0]            i_row,
    input  logic [WORD_W-1:0]     i_word,
    input  logic                  i_last,
    input  logic                  i_overflow,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending,
    output int unsigned           o_words_checked
);

    localparam t_word FILL_AT_RESET = 32'h2222_2222;
    localparam int unsigned MAX_REPORTS = 10;

    // Advance in pixels of each printable code, starting at the space.
    localparam logic [3:0] ADVANCE [96] = '{
        4'd3, 4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3,
        4'd3, 4'd3, 4'd6, 4'd6, 4'd3, 4'd5, 4'd3, 4'd5,
        4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd5, 4'd5, 4'd6,
        4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd7,
        4'd6, 4'd7, 4'd6, 4'd3, 4'd5, 4'd3, 4'd6, 4'd5,
        4'd3, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd3, 4'd6, 4'd6, 4'd3, 4'd7, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7,
        4'd7, 4'd6, 4'd6, 4'd4, 4'd2, 4'd4, 4'd7, 4'd1
    };

    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile;
        logic [2:0]            row;
        t_word                 word;
        logic                  last;
        logic                  overflow;
    } tile_word_t;

    t_word       line_tiles [MAX_TILES*8];
    t_word       fill_word;
    logic [2:0]  pen_offset;
    int unsigned tile_cursor;
    tile_word_t  expected_words [$];
    int unsigned fail_count = 0;
    int unsigned report_count = 0;
    int unsigned words_checked = 0;

    function automatic t_word opaque_nibbles(input t_word pix);
        t_word m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (pix[4*k +: 4] != 4'h0) begin
                m[4*k +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    // Merges one glyph into the line and queues the tile words it produces.
    task automatic blit_glyph(input logic [6:0] code, input glyph_rows_t rows);
        int unsigned width;
        int unsigned off;
        int unsigned parts;
        int unsigned tile;
        logic        ovf;
        t_word       pix;
        t_word       mask;
        t_word       word;
        tile_word_t  w;
        width = (code >= 7'd32) ? ADVANCE[code - 7'd32] : 0;
        off = pen_offset;
        parts = (off + width >= 8) ? 2 : 1;
        ovf = (tile_cursor + parts > MAX_TILES);
        for (int p = 0; p < parts; p++) begin
            for (int r = 0; r < 8; r++) begin
                tile = tile_cursor + p;
                if (p == 0) begin
                    pix = rows[r] << (4 * off);
                end else begin
                    pix = (off == 0) ? '0 : rows[r] >> (4 * (8 - off));
                end
                mask = opaque_nibbles(pix);
                word = '0;
                if (tile < MAX_TILES) begin
                    word = (line_tiles[tile*8 + r] & ~mask) | (pix & mask);
                    line_tiles[tile*8 + r] = word;
                end
                w.tile = TILE_IDX_W'(tile);
                w.row = 3'(r);
                w.word = word;
                w.last = (p == parts - 1) && (r == 7);
                w.overflow = ovf;
                expected_words.push_back(w);
            end
        end
        if (parts == 2) begin
            pen_offset = 3'(off + width - 8);
            if (tile_cursor < MAX_TILES) begin
                tile_cursor++;
            end
        end else begin
            pen_offset = 3'(off + width);
        end
    endtask

    always @(posedge i_clk) begin
        tile_word_t want;
        if (!i_rst_n) begin
            fill_word = FILL_AT_RESET;
            pen_offset = '0;
            tile_cursor = 0;
            expected_words.delete();
        end else begin
            // Outputs first: a word can never belong to an item taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("unexpected word: tile %0d row %0d word %h last %b ovf %b",
                                 i_tile_index, i_row, i_word, i_last, i_overflow);
                    end
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (i_tile_index !== want.tile || i_row !== want.row ||
                        i_word !== want.word || i_last !== want.last ||
                        i_overflow !== want.overflow) begin
                        fail_count++;
                        if (report_count < MAX_REPORTS) begin
                            report_count++;
                            $display("mismatch: expected tile %0d row %0d word %h last %b ovf %b",
                                     want.tile, want.row, want.word, want.last, want.overflow);
                            $display("          actual   tile %0d row %0d word %h last %b ovf %b",
                                     i_tile_index, i_row, i_word, i_last, i_overflow);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                fill_word = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == ITEM_START) begin
                    for (int i = 0; i < MAX_TILES*8; i++) begin
                        line_tiles[i] = fill_word;
                    end
                    pen_offset = '0;
                    tile_cursor = 0;
                end else begin
                    blit_glyph(i_char_code, i_glyph);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_words.size();
        o_words_checked <= words_checked;
    end

endmodule

[verif/proportional_glyph_tile_blitter_tb.sv]
// ----------------------------------------------------------------------------
// proportional_glyph_tile_blitter_tb: stimulus and verdict for the glyph blitter
// Drives directed and random lines of text with random input gaps and output
// stalls through the block, changes the fill word between lines, and leaves all
// prediction and comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module proportional_glyph_tile_blitter_tb;
    import pgtb_pkg::*;
    import pgtb_tb_pkg::*;

    localparam int unsigned MAX_TILES     = 32;
    // The directed part sends 17 items; the random part brings the total to 210.
    localparam int unsigned RANDOM_ITEMS  = 193;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 24;
    // Cycles waited after the results drain, so that a trailing start item finishes.
    localparam int unsigned START_SLACK   = 4;

    // Character codes used by name in the directed part.
    localparam logic [6:0] CODE_NUL    = 7'd0;    // control code, zero advance
    localparam logic [6:0] CODE_US     = 7'd31;   // highest control code
    localparam logic [6:0] CODE_SPACE  = 7'd32;   // first printable code
    localparam logic [6:0] CODE_BANG   = 7'd33;   // narrow glyph
    localparam logic [6:0] CODE_WIDEST = 7'd64;   // the one glyph a full tile wide
    localparam logic [6:0] CODE_UPPERA = 7'd65;
    localparam logic [6:0] CODE_TILDE  = 7'd126;
    localparam logic [6:0] CODE_LAST   = 7'd127;  // one pixel advance

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [WORD_W-1:0]     cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    item_kind_e            kind_q    = ITEM_START;
    logic [6:0]            code_q    = '0;
    glyph_rows_t           glyph_q   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [TILE_IDX_W-1:0] out_tile;
    logic [2:0]            out_row;
    logic [WORD_W-1:0]     out_word;
    logic                  out_last;
    logic                  out_overflow;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned words_checked;

    // Set once the random lines begin; the result side then holds off once.
    bit          random_phase = 1'b0;
    int unsigned items_sent   = 0;
    int unsigned lines_drawn  = 0;
    int unsigned fill_writes  = 0;

    proportional_glyph_tile_blitter #(
        .MAX_TILES(MAX_TILES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_kind        (kind_q),
        .i_char_code   (code_q),
        .i_glyph_row_0 (glyph_q[0]),
        .i_glyph_row_1 (glyph_q[1]),
        .i_glyph_row_2 (glyph_q[2]),
        .i_glyph_row_3 (glyph_q[3]),
        .i_glyph_row_4 (glyph_q[4]),
        .i_glyph_row_5 (glyph_q[5]),
        .i_glyph_row_6 (glyph_q[6]),
        .i_glyph_row_7 (glyph_q[7]),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_tile_index  (out_tile),
        .o_row         (out_row),
        .o_word        (out_word),
        .o_last        (out_last),
        .o_overflow    (out_overflow)
    );

    pgtb_checker #(
        .MAX_TILES(MAX_TILES)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_kind          (kind_q),
        .i_char_code     (code_q),
        .i_glyph         (glyph_q),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_tile_index    (out_tile),
        .i_row           (out_row),
        .i_word          (out_word),
        .i_last          (out_last),
        .i_overflow      (out_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial begin
        #6_000_000;
        $display("proportional_glyph_tile_blitter_tb: errors");
        $finish;
    end

    // Sender idle time: half the items follow back to back, most of the rest
    // after a short pause, and a few after a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 8) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Rows are either fully random or sparse, so that both opaque and
    // transparent nibbles show up in quantity.
    function automatic glyph_rows_t random_rows();
        glyph_rows_t g;
        for (int r = 0; r < 8; r++) begin
            if ($urandom_range(0, 1) == 0) begin
                g[r] = $urandom;
            end else begin
                for (int k = 0; k < 8; k++) begin
                    g[r][4*k +: 4] = ($urandom_range(0, 1) == 0) ? 4'h0
                                                                 : 4'($urandom_range(1, 15));
                end
            end
        end
        return g;
    endfunction

    // Long lines lean on the full-width glyph so the cursor reaches the end of
    // the line and runs past it; only short lines carry an occasional control code.
    function automatic logic [6:0] random_code(input bit push_cursor);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (push_cursor && r < 12) begin
            return CODE_WIDEST;
        end
        if (r == 0) begin
            return 7'($urandom_range(0, 31));
        end
        return 7'($urandom_range(32, 127));
    endfunction

    // One transfer on the input channel. Valid is only lowered when a gap is
    // taken, so back-to-back items keep it high without a glitch.
    task automatic send_item(input item_kind_e kind, input logic [6:0] code,
                             input glyph_rows_t rows);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind_q   <= kind;
        code_q   <= code;
        glyph_q  <= rows;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering items until every predicted word has come out, then let a
    // trailing start item finish, since it produces nothing to wait on.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (START_SLACK) @(posedge i_clk);
    endtask

    task automatic write_fill_word(input logic [WORD_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        fill_writes++;
    endtask

    // Result side: random stalls, mostly short, with a few long stalls and long
    // stretches without any. Once the random lines begin it holds off for a
    // long while so that the block backs up and stalls its own input.
    initial begin : result_stall
        int unsigned r;
        int unsigned n;
        bit          hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (random_phase && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 9);
            if (r < 5) begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 8);
            end else if (r < 8) begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 3);
            end else if (r == 8) begin
                out_stall <= 1'b1;
                n = $urandom_range(10, 40);
            end else begin
                out_stall <= 1'b0;
                n = $urandom_range(30, 80);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned line_no;
        int unsigned glyph_count;
        bit          long_line;
        logic [WORD_W-1:0] next_fill;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The first line uses the fill word left by reset; the
        // tile store is never read before a start item has filled it.
        send_item(ITEM_START, 7'($urandom), random_rows());
        lines_drawn++;
        send_item(ITEM_GLYPH, CODE_SPACE, {8{32'hFFFF_FFFF}});
        // A fully transparent glyph must leave the tile words untouched.
        send_item(ITEM_GLYPH, CODE_LAST, '0);
        // Full-width glyph at a nonzero offset splits across two tiles.
        send_item(ITEM_GLYPH, CODE_WIDEST, {8{32'h8765_4321}});
        // Control codes merge at the current offset but do not move the pen.
        send_item(ITEM_GLYPH, CODE_NUL, random_rows());
        send_item(ITEM_GLYPH, CODE_US, {4{32'hF0F0_F0F0, 32'h0F0F_0F0F}});

        write_fill_word(32'h0000_0000);
        send_item(ITEM_START, CODE_WIDEST, random_rows());
        lines_drawn++;
        // Full-width glyph at offset zero: the second tile gets nothing new,
        // yet the cursor still moves on.
        send_item(ITEM_GLYPH, CODE_WIDEST, random_rows());
        send_item(ITEM_GLYPH, CODE_BANG, random_rows());
        send_item(ITEM_GLYPH, CODE_TILDE, random_rows());
        send_item(ITEM_GLYPH, CODE_UPPERA, random_rows());

        write_fill_word(32'hFFFF_FFFF);
        // The glyph fields of a start item are ignored, even when all ones.
        send_item(ITEM_START, CODE_LAST, {8{32'hFFFF_FFFF}});
        lines_drawn++;
        send_item(ITEM_GLYPH, CODE_WIDEST, '0);
        send_item(ITEM_GLYPH, CODE_WIDEST, {8{32'hFFFF_FFFF}});
        send_item(ITEM_GLYPH, random_code(1'b0), random_rows());
        // A start in the middle of a line throws the line away.
        send_item(ITEM_START, 7'($urandom), random_rows());
        lines_drawn++;
        send_item(ITEM_GLYPH, CODE_LAST, {8{32'hF000_0000}});

        // Random part: lines of text, each opened by a start item. The first
        // line is long enough to run the cursor past the last tile, and it follows the
        // directed part with no drain, so that it meets the long hold on the result side.
        random_phase = 1'b1;
        random_sent = 0;
        line_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            long_line = (line_no == 0) || ($urandom_range(0, 5) == 0);
            if (line_no != 0 && line_no % 4 == 0) begin
                case ((line_no / 4) % 4)
                    0:       next_fill = $urandom;
                    1:       next_fill = 32'h0000_0000;
                    2:       next_fill = 32'hFFFF_FFFF;
                    default: next_fill = $urandom;
                endcase
                write_fill_word(next_fill);
            end else if (line_no != 0 && $urandom_range(0, 4) == 0) begin
                // The sender waits for the result side to catch up entirely.
                drain_results();
            end
            send_item(ITEM_START, 7'($urandom), random_rows());
            random_sent++;
            lines_drawn++;
            glyph_count = long_line ? $urandom_range(42, 50) : $urandom_range(1, 12);
            if (glyph_count > RANDOM_ITEMS - random_sent) begin
                glyph_count = RANDOM_ITEMS - random_sent;
            end
            repeat (glyph_count) begin
                send_item(ITEM_GLYPH, random_code(long_line), random_rows());
                random_sent++;
            end
            line_no++;
        end

        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items over %0d lines and %0d fill word writes; %0d words compared.",
                 items_sent, lines_drawn, fill_writes, words_checked);
        $display("Included split, zero-width, transparent and past-the-end glyphs under backpressure.");
        if (fail_count == 0) begin
            $display("proportional_glyph_tile_blitter_tb: clean");
        end else begin
            $display("proportional_glyph_tile_blitter_tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pgtb_pkg.sv
rtl/core/pgtb_lane.sv
rtl/core/pgtb_merge.sv
rtl/core/proportional_glyph_tile_blitter.sv
verif/pgtb_tb_pkg.sv
verif/pgtb_checker.sv
verif/proportional_glyph_tile_blitter_tb.sv
